@@ hdl/jzs_pkg.sv @@
// ----------------------------------------------------------------------------
// jzs_pkg
// Types, constants and helpers shared by the JPEG/ZIP entry scanner.
// ----------------------------------------------------------------------------
package jzs_pkg;

  typedef enum logic [2:0] {
    PH_SOI  = 3'd0,
    PH_EOI  = 3'd1,
    PH_SIG  = 3'd2,
    PH_HDR  = 3'd3,
    PH_NAME = 3'd4,
    PH_SKIP = 3'd5,
    PH_DONE = 3'd6,
    PH_BAD  = 3'd7
  } jzs_phase_t;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;
  localparam logic [7:0] SIG_B0   = 8'h50;
  localparam logic [7:0] SIG_B1   = 8'h4B;
  localparam logic [7:0] SIG_B2   = 8'h03;
  localparam logic [7:0] SIG_B3   = 8'h04;

  localparam logic [4:0] HDR_CSIZE = 5'd14;
  localparam logic [4:0] HDR_NLEN  = 5'd22;
  localparam logic [4:0] HDR_XLEN  = 5'd24;
  localparam logic [4:0] HDR_LAST  = 5'd25;

  localparam logic [15:0] MAX_NAME  = 16'd512;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic       KIND_NAME   = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;
  localparam logic [1:0] VERD_NOT_JPEG = 2'd0;
  localparam logic [1:0] VERD_PLAIN    = 2'd1;
  localparam logic [1:0] VERD_ENTRIES  = 2'd2;

  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } jzs_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_byte;
    logic        name_last;
    logic [15:0] entry_index;
    logic [1:0]  verdict;
    logic [15:0] entries_found;
  } jzs_out_t;

  typedef struct packed {
    jzs_phase_t  phase;
    logic [1:0]  match_pos;
    logic [4:0]  hdr_pos;
    logic [31:0] packed_size;
    logic [15:0] name_length;
    logic [15:0] extra_length;
    logic [15:0] name_left;
    logic [32:0] skip_left;
    logic [15:0] entry_total;
    logic        jpeg_seen;
  } jzs_state_t;

  typedef struct packed {
    logic     name_vld;
    jzs_out_t name_item;
    logic     rpt_vld;
    jzs_out_t rpt_item;
  } jzs_emit_t;

  localparam jzs_state_t ST_RESET = '{phase: PH_SOI, default: '0};

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = SIG_B0;
      2'd1:    r = SIG_B1;
      2'd2:    r = SIG_B2;
      default: r = SIG_B3;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] name_cap(input logic [15:0] len);
    return (len < MAX_NAME) ? len : MAX_NAME;
  endfunction

endpackage

@@ hdl/jzs_step.sv @@
// ----------------------------------------------------------------------------
// jzs_step
// Next-state and result logic for one byte of the scanned stream.
// ----------------------------------------------------------------------------
module jzs_step import jzs_pkg::*; (
  input  jzs_state_t cur,
  input  jzs_in_t    in_item,
  output jzs_state_t nxt,
  output jzs_emit_t  emit
);

  logic [7:0]  b;
  logic [2:0]  p;
  logic [2:0]  p1;
  logic [15:0] pos;
  logic [15:0] cap;
  logic        last;
  logic [15:0] rpos;
  logic [15:0] rcap;
  logic [15:0] cnt;
  logic [32:0] skip_sum;

  assign b = in_item.data_byte;

  always_comb begin
    nxt      = cur;
    emit     = '0;
    p        = '0;
    p1       = '0;
    pos      = cur.name_length - cur.name_left;
    cap      = name_cap(cur.name_length);
    last     = 1'b0;
    skip_sum = {1'b0, cur.packed_size} + {17'd0, cur.extra_length};

    case (cur.phase)
      PH_SOI: begin
        if (cur.match_pos > 2'd1 || b != (cur.match_pos[0] ? MARK_SOI : MARK_FF)) begin
          nxt.phase     = PH_BAD;
          nxt.match_pos = '0;
        end else if (cur.match_pos == 2'd1) begin
          nxt.match_pos = '0;
          nxt.phase     = PH_EOI;
        end else begin
          nxt.match_pos = 2'd1;
        end
      end
      PH_EOI: begin
        p = (cur.match_pos >= 2'd2) ? 3'd0 : {1'b0, cur.match_pos};
        if (b == (p[0] ? MARK_EOI : MARK_FF)) begin
          p1 = p + 3'd1;
        end else begin
          p1 = (b == MARK_FF) ? 3'd1 : 3'd0;
        end
        if (p1 >= 3'd2) begin
          nxt.match_pos = '0;
          nxt.jpeg_seen = 1'b1;
          nxt.phase     = PH_SIG;
        end else begin
          nxt.match_pos = p1[1:0];
        end
      end
      PH_SIG: begin
        p = {1'b0, cur.match_pos};
        if (b == sig_byte(p[1:0])) begin
          p1 = p + 3'd1;
        end else begin
          p1 = (b == SIG_B0) ? 3'd1 : 3'd0;
        end
        if (p1 >= 3'd4) begin
          nxt.match_pos    = '0;
          nxt.phase        = PH_HDR;
          nxt.hdr_pos      = '0;
          nxt.packed_size  = '0;
          nxt.name_length  = '0;
          nxt.extra_length = '0;
        end else begin
          nxt.match_pos = p1[1:0];
        end
      end
      PH_HDR: begin
        case (cur.hdr_pos)
          HDR_CSIZE:         nxt.packed_size[7:0]   = b;
          HDR_CSIZE + 5'd1:  nxt.packed_size[15:8]  = b;
          HDR_CSIZE + 5'd2:  nxt.packed_size[23:16] = b;
          HDR_CSIZE + 5'd3:  nxt.packed_size[31:24] = b;
          HDR_NLEN:          nxt.name_length[7:0]   = b;
          HDR_NLEN + 5'd1:   nxt.name_length[15:8]  = b;
          HDR_XLEN:          nxt.extra_length[7:0]  = b;
          HDR_XLEN + 5'd1:   nxt.extra_length[15:8] = b;
          default: ;
        endcase
        if (cur.hdr_pos >= HDR_LAST) begin
          nxt.hdr_pos = '0;
          if (nxt.name_length == '0) begin
            nxt.phase = PH_DONE;
          end else begin
            nxt.name_left = nxt.name_length;
            nxt.phase     = PH_NAME;
          end
        end else begin
          nxt.hdr_pos = cur.hdr_pos + 5'd1;
        end
      end
      PH_NAME: begin
        if (pos < cap) begin
          last                          = (pos + 16'd1 == cap);
          emit.name_vld                 = 1'b1;
          emit.name_item.result_kind    = KIND_NAME;
          emit.name_item.name_byte      = b;
          emit.name_item.name_last      = last;
          emit.name_item.entry_index    = cur.entry_total;
          if (last && cur.entry_total != COUNT_MAX) begin
            nxt.entry_total = cur.entry_total + 16'd1;
          end
        end
        if (cur.name_left != '0) begin
          nxt.name_left = cur.name_left - 16'd1;
        end
        if (nxt.name_left == '0) begin
          nxt.skip_left = skip_sum;
          nxt.match_pos = '0;
          nxt.phase     = (skip_sum == '0) ? PH_SIG : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (cur.skip_left != '0) begin
          nxt.skip_left = cur.skip_left - 33'd1;
        end
        if (nxt.skip_left == '0) begin
          nxt.match_pos = '0;
          nxt.phase     = PH_SIG;
        end
      end
      default: ;
    endcase

    // end-of-stream report, then back to the reset state
    rpos = nxt.name_length - nxt.name_left;
    rcap = name_cap(nxt.name_length);
    cnt  = nxt.entry_total;
    if (in_item.stream_end) begin
      if (nxt.phase == PH_NAME && rpos != '0 && rpos < rcap && cnt != COUNT_MAX) begin
        cnt = cnt + 16'd1;
      end
      emit.rpt_vld                = 1'b1;
      emit.rpt_item.result_kind   = KIND_REPORT;
      emit.rpt_item.entries_found = cnt;
      if (!nxt.jpeg_seen) begin
        emit.rpt_item.verdict = VERD_NOT_JPEG;
      end else begin
        emit.rpt_item.verdict = (cnt == '0) ? VERD_PLAIN : VERD_ENTRIES;
      end
      nxt = ST_RESET;
    end
  end

endmodule

@@ hdl/jpeg_zip_entry_scanner.sv @@
// registered: with the result queue empty, a result reaches out_data in the cycle after its input transfer
// throughput: one byte per cycle while in_stall is low; a byte gives at most two results, queued together
// the four-entry result queue drains one result per cycle while out_stall is low; in_stall is high
// while it holds more than two results
// reset: synchronous rst_n returns the scanner to the start-of-image check
// and empties the result queue
// ----------------------------------------------------------------------------
// jpeg_zip_entry_scanner
// Checks a JPEG stream, walks the ZIP local headers appended to it and
// streams out the stored file names plus an end-of-stream report.
// ----------------------------------------------------------------------------
module jpeg_zip_entry_scanner import jzs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  jzs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output jzs_out_t out_data
);

  jzs_state_t state_r;
  jzs_state_t state_nxt;
  jzs_emit_t  emit;

  jzs_out_t   q_r   [QDEPTH];
  jzs_out_t   q_nxt [QDEPTH];
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic [2:0] base;
  logic [1:0] wr0;
  logic [1:0] wr1;
  logic       acc;
  logic       pop;

  jzs_step u_step (
    .cur     (state_r),
    .in_item (in_data),
    .nxt     (state_nxt),
    .emit    (emit)
  );

  assign acc       = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (cnt_r > 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[0];

  // result queue, head always at entry 0
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    base    = cnt_r - {2'd0, pop};
    wr0     = base[1:0];
    wr1     = base[1:0] + {1'b0, emit.name_vld};
    cnt_nxt = base;
    if (acc) begin
      if (emit.name_vld) begin
        q_nxt[wr0] = emit.name_item;
      end
      if (emit.rpt_vld) begin
        q_nxt[wr1] = emit.rpt_item;
      end
      cnt_nxt = base + {2'd0, emit.name_vld} + {2'd0, emit.rpt_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESET;
      cnt_r   <= '0;
    end else begin
      if (acc) begin
        state_r <= state_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.stream_end) |=>
      (state_r.phase == PH_SOI && state_r.entry_total == '0 && !state_r.jpeg_seen))
    else $error("scanner state not cleared after stream end");

  a_report_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.stream_end) |=> out_valid)
    else $error("stream end transfer left no result");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == KIND_REPORT) |->
      (out_data.verdict == VERD_NOT_JPEG || out_data.verdict == VERD_PLAIN ||
       out_data.verdict == VERD_ENTRIES))
    else $error("bad verdict code");

  a_soi_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_SOI) |-> (state_r.match_pos <= 2'd1))
    else $error("start marker match position out of range");
`endif

endmodule

@@ verif/jzs_scan_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jzs_scan_checker
// Watches both channels of the JPEG/ZIP entry scanner, predicts the name
// bytes and end-of-stream reports of every accepted byte, and compares each
// result transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module jzs_scan_checker import jzs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  jzs_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  jzs_out_t out_data,
  output int       scan_errors,
  output int       results_due
);

  localparam logic [31:0] EOI_PAT = {16'h0000, MARK_EOI, MARK_FF};
  localparam logic [31:0] SIG_PAT = {SIG_B3, SIG_B2, SIG_B1, SIG_B0};

  jzs_phase_t  ph;
  int unsigned mpos;
  int unsigned hpos;
  logic [31:0] csize;
  logic [15:0] nlen;
  logic [15:0] xlen;
  logic [15:0] nleft;
  logic [32:0] skip;
  logic [15:0] entries;
  logic        seen;

  jzs_out_t name_report_q[$];
  jzs_out_t want;

  task automatic clear_scan();
    ph      = PH_SOI;
    mpos    = 0;
    hpos    = 0;
    csize   = '0;
    nlen    = '0;
    xlen    = '0;
    nleft   = '0;
    skip    = '0;
    entries = '0;
    seen    = 1'b0;
  endtask

  // pattern hunt that restarts on the pattern's first byte
  function automatic bit match_step(input logic [7:0] b, input logic [31:0] pat,
                                    input int unsigned len);
    int unsigned p;
    p = (mpos >= len) ? 0 : mpos;
    if (b == pat[8*p +: 8]) begin
      p++;
    end else begin
      p = (b == pat[7:0]) ? 1 : 0;
    end
    if (p >= len) begin
      mpos = 0;
      return 1'b1;
    end
    mpos = p;
    return 1'b0;
  endfunction

  task automatic scan_byte(input jzs_in_t it);
    logic [7:0]  b;
    int unsigned p;
    int unsigned pos;
    int unsigned cap;
    int unsigned cnt;
    jzs_out_t    r;
    b = it.data_byte;
    case (ph)
      PH_SOI: begin
        if (mpos > 1 || b != ((mpos == 0) ? MARK_FF : MARK_SOI)) begin
          ph   = PH_BAD;
          mpos = 0;
        end else begin
          mpos++;
          if (mpos == 2) begin
            mpos = 0;
            ph   = PH_EOI;
          end
        end
      end
      PH_EOI: begin
        if (match_step(b, EOI_PAT, 2)) begin
          seen = 1'b1;
          ph   = PH_SIG;
        end
      end
      PH_SIG: begin
        if (match_step(b, SIG_PAT, 4)) begin
          ph    = PH_HDR;
          hpos  = 0;
          csize = '0;
          nlen  = '0;
          xlen  = '0;
        end
      end
      PH_HDR: begin
        p = hpos;
        if (p >= HDR_CSIZE && p < HDR_CSIZE + 4) begin
          csize[8*(p - HDR_CSIZE) +: 8] = b;
        end else if (p == HDR_NLEN || p == HDR_NLEN + 1) begin
          nlen[8*(p - HDR_NLEN) +: 8] = b;
        end else if (p == HDR_XLEN || p == HDR_LAST) begin
          xlen[8*(p - HDR_XLEN) +: 8] = b;
        end
        if (p >= HDR_LAST) begin
          hpos = 0;
          if (nlen == 0) begin
            ph = PH_DONE;
          end else begin
            nleft = nlen;
            ph    = PH_NAME;
          end
        end else begin
          hpos = p + 1;
        end
      end
      PH_NAME: begin
        pos = nlen - nleft;
        cap = (nlen < MAX_NAME) ? nlen : MAX_NAME;
        if (pos < cap) begin
          r             = '0;
          r.result_kind = KIND_NAME;
          r.name_byte   = b;
          r.name_last   = (pos + 1 == cap);
          r.entry_index = entries;
          name_report_q.push_back(r);
          if (r.name_last && entries < COUNT_MAX) entries++;
        end
        if (nleft > 0) nleft--;
        if (nleft == 0) begin
          skip = {1'b0, csize} + {17'd0, xlen};
          mpos = 0;
          ph   = (skip == 0) ? PH_SIG : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) begin
          mpos = 0;
          ph   = PH_SIG;
        end
      end
      default: ;
    endcase

    if (it.stream_end) begin
      cnt = entries;
      if (ph == PH_NAME) begin
        // a name cut short by the end still counts
        pos = nlen - nleft;
        cap = (nlen < MAX_NAME) ? nlen : MAX_NAME;
        if (pos > 0 && pos < cap && cnt < COUNT_MAX) cnt++;
      end
      r               = '0;
      r.result_kind   = KIND_REPORT;
      r.entries_found = cnt[15:0];
      if (!seen) begin
        r.verdict = VERD_NOT_JPEG;
      end else begin
        r.verdict = (cnt == 0) ? VERD_PLAIN : VERD_ENTRIES;
      end
      name_report_q.push_back(r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", fname, exp_val, act_val);
      scan_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      name_report_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (name_report_q.size() == 0) begin
          $error("result transfer with nothing pending: kind %0d", out_data.result_kind);
          scan_errors++;
        end else begin
          want = name_report_q.pop_front();
          check_field("result_kind", want.result_kind, out_data.result_kind);
          check_field("name_byte", want.name_byte, out_data.name_byte);
          check_field("name_last", want.name_last, out_data.name_last);
          check_field("entry_index", want.entry_index, out_data.entry_index);
          check_field("verdict", want.verdict, out_data.verdict);
          check_field("entries_found", want.entries_found, out_data.entries_found);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_data);
    end
    results_due = name_report_q.size();
  end

endmodule

@@ verif/tb_jpeg_zip_entry_scanner.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_zip_entry_scanner
// Streams short directed files and then random JPEG/ZIP files, mostly well
// formed with random headers, names and payloads, plus truncated and noisy
// ones, through the scanner under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_jpeg_zip_entry_scanner;
  import jzs_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  jzs_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  jzs_out_t out_data;

  int scan_errors;
  int results_due;
  int idle_mode     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int sent          = 0;
  int files         = 0;

  jzs_in_t file_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jpeg_zip_entry_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  jzs_scan_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .scan_errors (scan_errors),
    .results_due (results_due)
  );

  // receiver back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 47 : (idle_mode == 1) ? 32 : 0));
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_jpeg_zip_entry_scanner NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input jzs_in_t it);
    int send_pct;
    send_pct = (idle_mode == 0) ? 32 : (idle_mode == 1) ? 47 : 0;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    jzs_in_t it;
    it.data_byte  = b;
    it.stream_end = 1'b0;
    file_q.push_back(it);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
  endtask

  // bytes given most significant first
  task automatic add_seq(input logic [63:0] bytes, input int n);
    for (int i = 0; i < n; i++) add_byte(bytes[8*(n-1-i) +: 8]);
  endtask

  // local header; a partial entry gets at most 20 bytes of its name and at most six data bytes
  task automatic add_entry(input logic [15:0] nlen, input logic [31:0] csize,
                           input logic [15:0] xlen, input bit whole);
    int nbytes;
    add_byte(SIG_B0);
    add_byte(SIG_B1);
    add_byte(SIG_B2);
    add_byte(SIG_B3);
    for (int i = 0; i <= HDR_LAST; i++) begin
      if (i >= HDR_CSIZE && i < HDR_CSIZE + 4) add_byte(csize[8*(i - HDR_CSIZE) +: 8]);
      else if (i == HDR_NLEN || i == HDR_NLEN + 1) add_byte(nlen[8*(i - HDR_NLEN) +: 8]);
      else if (i >= HDR_XLEN) add_byte(xlen[8*(i - HDR_XLEN) +: 8]);
      else add_byte(8'($urandom_range(255)));
    end
    if (whole) begin
      add_random(nlen);
      add_random(int'(csize) + int'(xlen));
    end else begin
      nbytes = $urandom_range(20);
      add_random((nlen < nbytes) ? nlen : nbytes);
      add_random($urandom_range(6));
    end
  endtask

  task automatic send_file();
    file_q[file_q.size() - 1].stream_end = 1'b1;
    foreach (file_q[i]) send_item(file_q[i]);
    file_q.delete();
    files++;
  endtask

  task automatic build_random_file();
    int          kind;
    int          count;
    int          r;
    int          cut;
    bit          whole;
    logic [15:0] nlen;
    logic [31:0] csize;
    logic [15:0] xlen;
    kind = $urandom_range(99);
    if (kind < 8) begin
      add_random($urandom_range(1, 6));
    end else if (kind < 14) begin
      add_byte(MARK_FF);
      add_byte(MARK_SOI);
      add_random($urandom_range(0, 8));
    end else begin
      add_byte(MARK_FF);
      add_byte(MARK_SOI);
      add_random($urandom_range(0, 8));
      if ($urandom_range(3) == 0) add_byte(MARK_FF);
      add_byte(MARK_FF);
      add_byte(MARK_EOI);
      add_random($urandom_range(0, 4));
      count = $urandom_range(0, 3);
      for (int e = 0; e < count; e++) begin
        r = $urandom_range(9);
        if (r == 0) begin
          add_byte(SIG_B0);
        end else if (r == 1) begin
          add_byte(SIG_B0);
          add_byte(SIG_B1);
        end
        r     = $urandom_range(99);
        whole = ($urandom_range(99) >= 10);
        if (r < 6) nlen = '0;
        else if (r < 8) nlen = 16'($urandom_range(511, 514));
        else if (!whole && r < 40) nlen = 16'($urandom());
        else nlen = 16'($urandom_range(1, 10));
        csize = whole ? 32'($urandom_range(0, 12)) : $urandom();
        xlen  = whole ? 16'($urandom_range(0, 4)) : 16'($urandom());
        add_entry(nlen, csize, xlen, whole);
        if (!whole || nlen == 0) break;
        add_random($urandom_range(0, 3));
      end
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_seq(64'h00D8, 2);
    send_file();
    add_seq(64'hFF, 1);
    send_file();
    add_seq(64'hFFD9, 2);
    send_file();
    add_seq(64'hFFD8, 2);
    send_file();
    add_seq(64'hFFD8FFFFD9, 5);
    send_file();
    add_seq(64'hFFD812FFD9, 5);
    send_file();

    // restarted signature, overlong name, then a zero-length name
    add_seq(64'hFFD8FFD950, 5);
    add_entry(16'd513, 32'd2, 16'd1, 1'b1);
    add_entry(16'd0, 32'd0, 16'd0, 1'b1);
    add_random(4);
    send_file();

    while (sent < ITEM_TARGET) begin
      idle_mode = (sent < ITEM_TARGET / 3) ? 0 : (sent < 2 * ITEM_TARGET / 3) ? 1 : 2;
      if (files == 12) hold_requests++;
      if (files == 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
      end
      build_random_file();
      send_file();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scan_errors == 0) begin
      $display("tb_jpeg_zip_entry_scanner OK");
    end else begin
      $display("tb_jpeg_zip_entry_scanner NOT OK");
    end
    $finish;
  end

endmodule
